// ===== src/mslpd_pkg.sv =====
// Shared types and constants for the multi-slot length-prefixed deframer.
// No dependencies; imported by mslpd_step, the core top level and the testbench files.
package mslpd_pkg;

    localparam int NUM_SLOTS = 4;
    localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SLOT_W    = 2;
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 16;
    localparam int REPLY_W   = 3;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    localparam logic [BYTE_W-1:0]  START_BYTE = 8'h3C;   // '<'
    localparam logic [REPLY_W-1:0] NO_TARGET  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 1'd1;

    localparam logic [LEN_W-1:0] MAX_LEN_RST = 16'd172;

    localparam logic FUNC_BYTE  = 1'b0;
    localparam logic FUNC_RESET = 1'b1;

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_LEN_LO = 2'd1,
        PH_LEN_HI = 2'd2,
        PH_DATA   = 2'd3
    } phase_t;

    typedef struct packed {
        phase_t            phase;
        logic [LEN_W-1:0]  dlen;
        logic [LEN_W-1:0]  brcv;
    } slot_state_t;

    localparam slot_state_t SLOT_RESET = '{phase: PH_HUNT, dlen: '0, brcv: '0};

    typedef struct packed {
        logic               vld;
        logic [SLOT_W-1:0]  slot;
        logic [BYTE_W-1:0]  pbyte;
        logic               last;
        logic               abort;
        logic [LEN_W-1:0]   length;
        logic [REPLY_W-1:0] reply;
    } result_t;

endpackage

// ===== src/mslpd_step.sv =====
// Per-item update of one slot's parser state and the reply target.
// Purely combinational; depends on mslpd_pkg.
module mslpd_step (
    input  mslpd_pkg::slot_state_t                cur,
    input  logic                                  func,
    input  logic [mslpd_pkg::SLOT_W-1:0]          slot,
    input  logic [mslpd_pkg::BYTE_W-1:0]          data,
    input  logic                                  enable,
    input  logic [mslpd_pkg::LEN_W-1:0]           max_len,
    input  logic [mslpd_pkg::REPLY_W-1:0]         reply,
    output mslpd_pkg::slot_state_t                nxt,
    output logic                                  wr_en,
    output logic [mslpd_pkg::REPLY_W-1:0]         reply_next,
    output mslpd_pkg::result_t                    res
);
    import mslpd_pkg::*;

    logic             in_range;
    logic [LEN_W-1:0] cnt_inc;
    logic [LEN_W-1:0] len_full;
    logic             is_last;

    assign in_range = (32'(slot) < NUM_SLOTS);
    assign cnt_inc  = cur.brcv + LEN_W'(1);
    assign len_full = {data, cur.dlen[BYTE_W-1:0]};
    assign is_last  = (cnt_inc >= cur.dlen);

    // next state
    always_comb begin
        nxt        = cur;
        wr_en      = in_range;
        reply_next = reply;
        if (in_range) begin
            if (func == FUNC_RESET) begin
                nxt = SLOT_RESET;
                if (reply == REPLY_W'(slot)) begin
                    reply_next = NO_TARGET;
                end
            end else if (enable) begin
                case (cur.phase)
                    PH_HUNT: begin
                        if (data == START_BYTE) begin
                            nxt.phase = PH_LEN_LO;
                        end
                    end
                    PH_LEN_LO: begin
                        nxt.dlen  = LEN_W'(data);
                        nxt.phase = PH_LEN_HI;
                    end
                    PH_LEN_HI: begin
                        nxt.dlen = len_full;
                        nxt.brcv = '0;
                        if (len_full == '0 || len_full > max_len) begin
                            nxt.phase = PH_HUNT;
                        end else begin
                            nxt.phase = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        if (is_last) begin
                            nxt.phase  = PH_HUNT;
                            nxt.brcv   = '0;
                            reply_next = REPLY_W'(slot);
                        end else begin
                            nxt.brcv = cnt_inc;
                        end
                    end
                    default: nxt = cur;
                endcase
            end
        end
    end

    // result
    always_comb begin
        res        = '0;
        res.slot   = slot;
        res.length = cur.dlen;
        res.reply  = reply_next;
        if (in_range && cur.phase == PH_DATA) begin
            if (func == FUNC_RESET) begin
                res.vld   = 1'b1;
                res.abort = 1'b1;
            end else if (enable) begin
                res.vld   = 1'b1;
                res.pbyte = data;
                res.last  = is_last;
            end
        end
    end

endmodule

// ===== src/multi_slot_length_prefixed_deframer_core.sv =====
// Top level of the multi-slot length-prefixed deframer.
// Depends on mslpd_pkg and mslpd_step.
//
// The core takes one item per cycle while the output is not stalled: either a received byte for a channel slot
// (s_tuser func = 0) or a slot reset (func = 1). Each slot runs its own parser:
// hunt for '<', take a little-endian 16-bit length, then stream that many
// payload bytes out, one result per byte, with m_tlast on the final one. Zero
// lengths and lengths above the configured maximum length send the slot back to hunting. A slot
// reset during a payload yields one abort result (m_tuser abort set, byte zero).
// Header bytes, hunted bytes, bytes while disabled and resets outside a payload
// yield no result. Every result carries the reply target, the slot that last
// completed a frame (4 = none); a reset of that slot clears it.
// Throughput is one item per clock while m_tready is high; an item passes two
// register stages, the update stage and then the output register, before its
// result is valid on the m_ side. Per-slot state
// sits in a small synchronous RAM: the read is issued at acceptance, the update
// is written back when the item leaves the update stage, and the last write is
// forwarded to the next item so back-to-back items on the same slot see fresh
// state. After reset every entry reads as hunting via per-entry valid bits; no
// clearing pass is needed.
// Configuration writes (cfg_ready is always high) are meant only while idle.
module multi_slot_length_prefixed_deframer_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input item stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,   // [7:0] data_in
    input  logic [2:0]                           s_tuser,   // [0] func, [2:1] slot
    // result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [31:0]                          m_tdata,   // [7:0] payload_byte,
                                                            // [23:8] frame_length,
                                                            // [26:24] reply_slot, rest 0
    output logic                                 m_tlast,   // frame_last
    output logic [2:0]                           m_tuser,   // [1:0] out_slot, [2] frame_abort
    // configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mslpd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mslpd_pkg::CFG_DAT_W-1:0]      cfg_data
);
    import mslpd_pkg::*;

    // configuration
    logic             enable_reg;
    logic [LEN_W-1:0] max_len_reg;

    // state RAM and its bookkeeping
    slot_state_t      mem [NUM_SLOTS];
    slot_state_t      rd_data_reg;
    logic [NUM_SLOTS-1:0] vld_reg;
    logic             fwd_valid_reg;
    logic [IDX_W-1:0] fwd_idx_reg;
    slot_state_t      fwd_data_reg;

    // update stage
    logic              st_valid_reg;
    logic              st_func_reg;
    logic [SLOT_W-1:0] st_slot_reg;
    logic [BYTE_W-1:0] st_data_reg;
    logic [REPLY_W-1:0] reply_reg;

    // output register
    logic               m_valid_reg;
    result_t            out_reg;

    logic             out_free;
    logic             st_adv;
    logic             s_accept;
    logic [IDX_W-1:0] in_idx;
    logic [IDX_W-1:0] st_idx;
    slot_state_t      cur_state;
    slot_state_t      nxt_state;
    logic             step_wr;
    logic             mem_wr;
    logic [REPLY_W-1:0] reply_next;
    result_t          step_res;

    assign out_free = !m_valid_reg || m_tready;
    assign st_adv   = st_valid_reg && out_free;
    assign s_tready = !st_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;
    assign in_idx   = IDX_W'(s_tuser[2:1]);
    assign st_idx   = IDX_W'(st_slot_reg);
    assign mem_wr   = st_adv && step_wr;
    assign cfg_ready = 1'b1;

    // pick freshest copy: same-edge write, then RAM, else the reset state
    always_comb begin
        if (fwd_valid_reg && fwd_idx_reg == st_idx) begin
            cur_state = fwd_data_reg;
        end else if (vld_reg[st_idx]) begin
            cur_state = rd_data_reg;
        end else begin
            cur_state = SLOT_RESET;
        end
    end

    mslpd_step u_step (
        .cur        (cur_state),
        .func       (st_func_reg),
        .slot       (st_slot_reg),
        .data       (st_data_reg),
        .enable     (enable_reg),
        .max_len    (max_len_reg),
        .reply      (reply_reg),
        .nxt        (nxt_state),
        .wr_en      (step_wr),
        .reply_next (reply_next),
        .res        (step_res)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg  <= 1'b0;
            max_len_reg <= MAX_LEN_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_ENABLE:  enable_reg  <= cfg_data[0];
                CFG_MAX_LEN: max_len_reg <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // state RAM: read at acceptance, write back from the update stage
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rd_data_reg <= mem[in_idx];
        end
        if (mem_wr) begin
            mem[st_idx] <= nxt_state;
        end
    end

    // forward the write that lands on the same edge as the next read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else if (s_accept) begin
            fwd_valid_reg <= mem_wr;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            fwd_idx_reg  <= st_idx;
            fwd_data_reg <= nxt_state;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (mem_wr) begin
            vld_reg[st_idx] <= 1'b1;
        end
    end

    // update stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
            reply_reg    <= NO_TARGET;
        end else begin
            if (s_accept) begin
                st_valid_reg <= 1'b1;
            end else if (st_adv) begin
                st_valid_reg <= 1'b0;
            end
            if (st_adv) begin
                reply_reg <= reply_next;
            end
        end
    end

    // update stage payload: hold while stalled
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            st_func_reg <= s_tuser[0];
            st_slot_reg <= s_tuser[2:1];
            st_data_reg <= s_tdata;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= st_adv && step_res.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (st_adv && step_res.vld) begin
            out_reg <= step_res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, out_reg.reply, out_reg.length, out_reg.pbyte};
    assign m_tlast  = out_reg.last;
    assign m_tuser  = {out_reg.abort, out_reg.slot};

    // an abort never closes a frame and never carries payload
    a_abort_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && out_reg.abort |-> !out_reg.last && out_reg.pbyte == '0)
        else $error("abort result carries last marker or payload");

    // a completed frame names its own slot as reply target
    a_last_reply: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && out_reg.last |-> out_reg.reply == REPLY_W'(out_reg.slot))
        else $error("completed frame does not set reply target");

    // reply target is either none or a real slot
    a_reply_range: assert property (@(posedge aclk) disable iff (!aresetn)
        reply_reg == NO_TARGET || 32'(reply_reg) < NUM_SLOTS)
        else $error("reply target out of range");

    // a payload result comes only from a slot in payload phase
    a_res_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        st_adv && step_res.vld |-> cur_state.phase == PH_DATA)
        else $error("result from slot outside payload");

    // the update stage moves on whenever the output side is free
    a_no_stuck: assert property (@(posedge aclk) disable iff (!aresetn)
        st_valid_reg && out_free && !s_accept |=> !st_valid_reg)
        else $error("update stage held with free output");

endmodule

// ===== sim/mslpd_frame_checker.sv =====
// Scoreboard for the multi-slot length-prefixed deframer: watches all three channels,
// predicts each result from its own copy of the per-slot parsers and compares.
// Depends on mslpd_pkg only.
`timescale 1ns / 1ps

module mslpd_frame_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [7:0]                      s_tdata,
    input  logic [2:0]                      s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [31:0]                     m_tdata,
    input  logic                            m_tlast,
    input  logic [2:0]                      m_tuser,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [mslpd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mslpd_pkg::CFG_DAT_W-1:0] cfg_data,
    output int                              outstanding,
    output int                              fail_count
);
    import mslpd_pkg::*;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic [BYTE_W-1:0]  pbyte;
        logic               last;
        logic               abort;
        logic [LEN_W-1:0]   flen;
        logic [REPLY_W-1:0] reply;
    } deframed_t;

    logic               enable_q;
    logic [LEN_W-1:0]   max_len_q;
    phase_t             phase_q   [NUM_SLOTS];
    logic [LEN_W-1:0]   decl_len_q[NUM_SLOTS];
    logic [LEN_W-1:0]   rcvd_q    [NUM_SLOTS];
    logic [REPLY_W-1:0] reply_tgt;

    deframed_t deframed_q[$];
    int        errs = 0;

    assign fail_count = errs;

    // Advance one slot parser by one item; return 1 when the item yields a result.
    function automatic bit deframe_item(input logic fn, input logic [SLOT_W-1:0] sl,
                                        input logic [BYTE_W-1:0] b, output deframed_t r);
        bit hit;
        r = '0;
        hit = 1'b0;
        if (int'(sl) >= NUM_SLOTS)
            return 1'b0;
        r.slot = sl;
        r.flen = decl_len_q[sl];
        if (fn == FUNC_RESET) begin
            // a reset inside the payload reports an abort; elsewhere it is silent
            hit = (phase_q[sl] == PH_DATA);
            r.abort = 1'b1;
            phase_q[sl] = PH_HUNT;
            decl_len_q[sl] = '0;
            rcvd_q[sl] = '0;
            if (reply_tgt == {1'b0, sl})
                reply_tgt = NO_TARGET;
        end else if (enable_q) begin
            case (phase_q[sl])
                PH_HUNT: begin
                    if (b == START_BYTE)
                        phase_q[sl] = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    decl_len_q[sl] = {8'd0, b};
                    phase_q[sl] = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    decl_len_q[sl] = {b, decl_len_q[sl][7:0]};
                    rcvd_q[sl] = '0;
                    if (decl_len_q[sl] == '0 || decl_len_q[sl] > max_len_q)
                        phase_q[sl] = PH_HUNT;
                    else
                        phase_q[sl] = PH_DATA;
                end
                default: begin
                    hit = 1'b1;
                    rcvd_q[sl] = rcvd_q[sl] + LEN_W'(1);
                    r.pbyte = b;
                    r.last = (rcvd_q[sl] >= decl_len_q[sl]);
                    if (r.last) begin
                        phase_q[sl] = PH_HUNT;
                        rcvd_q[sl] = '0;
                        reply_tgt = {1'b0, sl};
                    end
                end
            endcase
        end
        r.reply = reply_tgt;
        return hit;
    endfunction

    task automatic note_failure(input string what);
        errs++;
        if (errs <= 10)
            $display("[%0t] %s", $realtime, what);
    endtask

    always @(posedge aclk) begin : watch
        deframed_t want;
        deframed_t got;
        if (!aresetn) begin
            enable_q = 1'b0;
            max_len_q = MAX_LEN_RST;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                phase_q[IDX_W'(i)] = PH_HUNT;
                decl_len_q[IDX_W'(i)] = '0;
                rcvd_q[IDX_W'(i)] = '0;
            end
            reply_tgt = NO_TARGET;
            deframed_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ENABLE:  enable_q = cfg_data[0];
                    CFG_MAX_LEN: max_len_q = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (deframe_item(s_tuser[0], s_tuser[2:1], s_tdata, want))
                    deframed_q.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got.slot  = m_tuser[1:0];
                got.abort = m_tuser[2];
                got.pbyte = m_tdata[7:0];
                got.flen  = m_tdata[23:8];
                got.reply = m_tdata[26:24];
                got.last  = m_tlast;
                if (deframed_q.size() == 0) begin
                    note_failure($sformatf("unexpected result: slot %0d byte %02h last %0b",
                                           got.slot, got.pbyte, got.last));
                end else begin
                    want = deframed_q.pop_front();
                    if (got !== want || m_tdata[31:27] !== 5'd0)
                        note_failure($sformatf({"mismatch: got slot %0d byte %02h last %0b ",
                            "abort %0b len %0d reply %0d pad %02h / expected slot %0d ",
                            "byte %02h last %0b abort %0b len %0d reply %0d"},
                            got.slot, got.pbyte, got.last, got.abort, got.flen, got.reply,
                            m_tdata[31:27], want.slot, want.pbyte, want.last, want.abort,
                            want.flen, want.reply));
                end
            end
        end
        outstanding <= deframed_q.size();
    end

endmodule

// ===== sim/multi_slot_length_prefixed_deframer_core_tb.sv =====
// Testbench top for multi_slot_length_prefixed_deframer_core: clock, reset, stimulus
// and verdict. Depends on mslpd_pkg, the core and mslpd_frame_checker.
`timescale 1ns / 1ps

module multi_slot_length_prefixed_deframer_core_tb;
    import mslpd_pkg::*;

    // Let the pipeline drain before touching registers.
    localparam int SETTLE = 4;
    // Roughly 600 items, each at worst the longest random gap plus a tight receiver: far below this.
    localparam int unsigned LIMIT = 300000;

    typedef enum logic [1:0] {
        RX_OPEN,        // always ready
        RX_COIN,        // ready half the time
        RX_TIGHT,       // ready a quarter of the time on average
        RX_PERIODIC     // fixed pattern, low whenever rx_left is a multiple of four
    } rx_mode_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = '0;
    logic [2:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [31:0]          m_tdata;
    logic                 m_tlast;
    logic [2:0]           m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;
    int                   outstanding;
    int                   fail_count;

    int unsigned cycles = 0;
    rx_mode_t    rx_mode = RX_OPEN;
    int          rx_left = 0;
    int          burst_left = 0;

    // Frame plan per slot: position in the frame (0 = about to hunt/start, 1 = length low,
    // 2 = length high, 3.. = payload), declared length, payload bytes to send, and whether
    // to cut the frame short with a slot reset.
    logic [LEN_W-1:0] cur_max = MAX_LEN_RST;
    int               fr_pos [NUM_SLOTS];
    logic [LEN_W-1:0] fr_len [NUM_SLOTS];
    int               fr_send[NUM_SLOTS];
    bit               fr_cut [NUM_SLOTS];

    always #5 aclk = ~aclk;

    multi_slot_length_prefixed_deframer_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mslpd_frame_checker frame_chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    // Hard stop in case a handshake never completes.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver back-pressure: switch at random between stall styles.
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(20, 120);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:  m_tready <= 1'b1;
            RX_COIN:  m_tready <= ($urandom_range(0, 1) == 1);
            RX_TIGHT: m_tready <= ($urandom_range(0, 3) == 0);
            default:  m_tready <= (rx_left % 4 != 0);
        endcase
    end

    // Offer one item and hold it until accepted. Between bursts, drop valid for a
    // random gap, possibly none; within a burst keep valid high and just swap the payload.
    task automatic put_item(input logic fn, input logic [SLOT_W-1:0] sl,
                            input logic [BYTE_W-1:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= {sl, fn};
        do @(posedge aclk); while (!s_tready);
        burst_left--;
    endtask

    // Stop sending, wait for every expected result, then let the pipeline settle.
    task automatic go_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Write both registers back to back; valid stays high across the pair.
    task automatic program_regs(input logic en, input logic [LEN_W-1:0] max_len);
        cur_max = max_len;
        cfg_valid <= 1'b1;
        cfg_index <= CFG_ENABLE;
        cfg_data  <= {{(CFG_DAT_W-1){1'b0}}, en};
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= CFG_MAX_LEN;
        cfg_data  <= max_len;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Produce the next item of a slot's planned frame: junk while hunting, start byte,
    // two length bytes, payload, and optionally a reset that cuts the payload short.
    function automatic void plan_next(input logic [SLOT_W-1:0] sl, output logic fn,
                                      output logic [7:0] b);
        int r;
        logic [LEN_W-1:0] len;
        fn = FUNC_BYTE;
        b = 8'($urandom_range(0, 255));
        case (fr_pos[sl])
            0: begin
                if ($urandom_range(0, 6) == 0) begin
                    if (b == START_BYTE)
                        b = ~START_BYTE;
                end else begin
                    r = $urandom_range(0, 19);
                    if (r < 13)
                        len = LEN_W'($urandom_range(1, 8));
                    else if (r < 15)
                        len = '0;
                    else if (r < 17)
                        len = (cur_max != 16'hFFFF) ? cur_max + LEN_W'(1) : 16'hFFFF;
                    else if (r < 19)
                        len = (cur_max != '0) ? cur_max : 16'd1;
                    else
                        len = LEN_W'($urandom_range(256, 65535));
                    fr_len[sl] = len;
                    fr_cut[sl] = 1'b0;
                    fr_send[sl] = 0;
                    if (len != '0 && len <= cur_max) begin
                        fr_send[sl] = int'(len);
                        // long frames always get cut; short ones now and then
                        if (len > 12 || $urandom_range(0, 9) == 0) begin
                            fr_send[sl] = $urandom_range(0, (len > 7) ? 6 : int'(len) - 1);
                            fr_cut[sl] = 1'b1;
                        end
                    end
                    b = START_BYTE;
                    fr_pos[sl] = 1;
                end
            end
            1: begin
                b = fr_len[sl][7:0];
                fr_pos[sl] = 2;
            end
            2: begin
                b = fr_len[sl][15:8];
                fr_pos[sl] = (fr_send[sl] == 0 && !fr_cut[sl]) ? 0 : 3;
            end
            default: begin
                if (fr_pos[sl] - 3 < fr_send[sl]) begin
                    fr_pos[sl]++;
                    if (fr_pos[sl] - 3 == fr_send[sl] && !fr_cut[sl])
                        fr_pos[sl] = 0;
                end else begin
                    fn = FUNC_RESET;
                    fr_pos[sl] = 0;
                end
            end
        endcase
    endfunction

    // Mostly well-formed frames interleaved across slots, with stray resets and noise.
    task automatic run_phase(input logic en, input logic [LEN_W-1:0] max_len, input int n);
        int r;
        logic [SLOT_W-1:0] sl;
        logic fn;
        logic [7:0] b;
        go_idle();
        program_regs(en, max_len);
        repeat (n) begin
            r = $urandom_range(0, 99);
            sl = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
            if (r < 4) begin
                fn = FUNC_RESET;
                b = 8'($urandom_range(0, 255));
                fr_pos[sl] = 0;
            end else if (r < 8) begin
                fn = FUNC_BYTE;
                b = 8'($urandom_range(0, 255));
            end else begin
                plan_next(sl, fn, b);
            end
            put_item(fn, sl, b);
        end
    endtask

    initial begin
        for (int i = 0; i < NUM_SLOTS; i++)
            fr_pos[IDX_W'(i)] = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Out of reset the block is disabled: drop the byte; a reset while hunting is silent.
        put_item(FUNC_BYTE, 2'd0, START_BYTE);
        put_item(FUNC_RESET, 2'd0, 8'hFF);

        go_idle();
        program_regs(1'b1, MAX_LEN_RST);
        // Two-byte frame on slot 1: payload byte extremes, last marks slot 1 as reply target.
        put_item(FUNC_BYTE, 2'd1, START_BYTE);
        put_item(FUNC_BYTE, 2'd1, 8'h02);
        put_item(FUNC_BYTE, 2'd1, 8'h00);
        put_item(FUNC_BYTE, 2'd1, 8'h00);
        put_item(FUNC_BYTE, 2'd1, 8'hFF);
        // Reset the reply target's slot while hunting: target goes back to none.
        put_item(FUNC_RESET, 2'd1, 8'h00);
        // Zero length, then one above the limit: both resync to hunting.
        put_item(FUNC_BYTE, 2'd2, START_BYTE);
        put_item(FUNC_BYTE, 2'd2, 8'h00);
        put_item(FUNC_BYTE, 2'd2, 8'h00);
        put_item(FUNC_BYTE, 2'd2, START_BYTE);
        put_item(FUNC_BYTE, 2'd2, 8'hAD);
        put_item(FUNC_BYTE, 2'd2, 8'h00);

        go_idle();
        program_regs(1'b1, 16'hFFFF);
        // Largest length accepted, one payload byte, then abort by slot reset.
        put_item(FUNC_BYTE, 2'd3, START_BYTE);
        put_item(FUNC_BYTE, 2'd3, 8'hFF);
        put_item(FUNC_BYTE, 2'd3, 8'hFF);
        put_item(FUNC_BYTE, 2'd3, 8'hA5);
        put_item(FUNC_RESET, 2'd3, 8'h5A);

        go_idle();
        program_regs(1'b1, 16'h0000);
        // Zero limit rejects even a one-byte frame.
        put_item(FUNC_BYTE, 2'd0, START_BYTE);
        put_item(FUNC_BYTE, 2'd0, 8'h01);
        put_item(FUNC_BYTE, 2'd0, 8'h00);

        go_idle();
        program_regs(1'b1, 16'h0001);
        // One-byte frame at the limit; payload equal to the start byte passes through.
        put_item(FUNC_BYTE, 2'd2, START_BYTE);
        put_item(FUNC_BYTE, 2'd2, 8'h01);
        put_item(FUNC_BYTE, 2'd2, 8'h00);
        put_item(FUNC_BYTE, 2'd2, START_BYTE);

        // Random traffic across several register settings, extremes included.
        run_phase(1'b1, MAX_LEN_RST, 120);
        run_phase(1'b1, 16'd5, 120);
        run_phase(1'b1, 16'hFFFF, 100);
        run_phase(1'b0, 16'd8, 30);
        run_phase(1'b1, 16'd1, 60);
        run_phase(1'b1, 16'd0, 40);
        run_phase(1'b1, 16'($urandom_range(2, 40)), 100);

        go_idle();
        repeat (SETTLE) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
